### src/pfc_pkg.sv
// shared types, constants and helpers for the pose frame correction block
package pfc_pkg;

    // cordic configuration
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < 1) ? 1 :
                                  (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(ATAN_LEN);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_N - 1);

    // datapath widths
    localparam int CORDIC_W = 33;               // rotation vector, q30 with headroom
    localparam int Z_W      = 34;               // residual angle, 2^32 per turn
    localparam int OP_W     = 17;               // position operand incl. difference
    localparam int PROD_W   = OP_W + CORDIC_W;  // one partial product
    localparam int ACC_W    = PROD_W + 2;       // sum of two products
    localparam int RES_W    = ACC_W - 30 + 1;   // rounded sum plus offset

    localparam logic signed [CORDIC_W-1:0] CORDIC_START = CORDIC_W'(32'h26DD3B6A);
    localparam logic signed [ACC_W-1:0]    RND_HALF     = ACC_W'(64'd1 << 29);
    localparam logic signed [RES_W-1:0]    POS_MAX      = RES_W'(32767);
    localparam logic signed [RES_W-1:0]    POS_MIN      = RES_W'(-32768);

    // action codes
    typedef enum logic [1:0] {
        ACT_TO_TABLE = 2'd0,
        ACT_TO_ODOM  = 2'd1,
        ACT_SET      = 2'd2,
        ACT_COMPOSE  = 2'd3
    } t_action;

    // partial product selection
    typedef enum logic [1:0] {
        MS_AC = 2'd0,
        MS_BS = 2'd1,
        MS_BC = 2'd2,
        MS_AS = 2'd3
    } t_mul_sel;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    // transaction payloads
    typedef struct packed {
        t_action            action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic        [15:0] pos_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic        [15:0] out_angle;
        logic               saturated;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              cordic_step;
        logic [STEP_W-1:0] step_idx;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic              acc_en;
        t_mul_sel          acc_sel;
        logic              finish;
    } t_cmd;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### src/pose_frame_correction.sv
// top level of the pose frame correction block
// sequence: a set goes from idle straight to the done state; transforms and compose run the
// iterative cordic, then the four passes of the shared multiplier and a last accumulate
// order: one transaction at a time; the done state holds while the output register is still
// full and stalled, and the next input is taken while a result waits
// reset: synchronous active low, clears the correction to zero and empties the block
module pose_frame_correction (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pfc_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output pfc_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import pfc_pkg::*;

    t_cmd cmd;
    logic is_set;

    assign is_set = (i_in_data.action == ACT_SET);

    // controller
    pfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_is_set    (is_set),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath
    pfc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

    // an accepted transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a transaction");

    // finishing always presents a result
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_out_valid)
        else $error("finished transaction did not reach the output");

    // cordic iterations and multiplies only run while input is held off
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cordic_step || cmd.mul_en) |-> o_in_stall)
        else $error("datapath busy while input is open");

    // finishing never overwrites a result still held by the sink
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

### src/pfc_ctrl.sv
// controller state machine sequencing cordic, products and result hand-off
module pfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_is_set,
    input  logic          i_out_stall,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output pfc_pkg::t_cmd o_cmd
);
    import pfc_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_out_vld, n_out_vld;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && i_out_stall;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_is_set ? S_DONE : S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.step_idx    = r_cnt;
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                // accumulate trails the multiply, taking the product registered in the cycle before
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = t_mul_sel'(r_cnt[1:0]);
                o_cmd.acc_en  = (r_cnt[1:0] != 2'd0);
                o_cmd.acc_sel = t_mul_sel'(r_cnt[1:0] - 2'd1);
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ACC: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_sel = MS_AS;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_vld || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

### src/pfc_dpath.sv
// datapath: correction registers, cordic, shared multiplier, rounding and clamp
module pfc_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfc_pkg::t_cmd      i_cmd,
    input  pfc_pkg::t_in_item  i_in_data,
    output pfc_pkg::t_out_item o_out_data
);
    import pfc_pkg::*;

    // correction state
    logic signed [15:0] r_corr_x, r_corr_y;
    logic        [15:0] r_corr_a;

    // per transaction operands
    t_action                   r_act;
    logic        [15:0]        r_pa;
    logic signed [OP_W-1:0]    r_a, r_b;
    logic signed [15:0]        r_offx, r_offy;
    logic                      r_flip;

    // cordic vector and residual angle
    logic signed [CORDIC_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0]      r_z;

    // product and accumulators
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_accx, r_accy;

    t_out_item r_out;

    // angle fold for the loaded transaction
    logic [15:0] ang_src, ang_fold;
    logic        fold;
    always_comb begin
        ang_src  = (i_in_data.action == ACT_COMPOSE) ? i_in_data.pos_angle : r_corr_a;
        fold     = (ang_src[15:14] == 2'b01) || (ang_src[15:14] == 2'b10);
        ang_fold = fold ? (ang_src ^ 16'h8000) : ang_src;
    end

    // load operands on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_in_data.action;
            r_pa   <= i_in_data.pos_angle;
            r_flip <= fold;
            unique case (i_in_data.action)
                ACT_TO_TABLE: begin
                    r_a    <= OP_W'(i_in_data.pos_x);
                    r_b    <= OP_W'(i_in_data.pos_y);
                    r_offx <= r_corr_x;
                    r_offy <= r_corr_y;
                end
                ACT_TO_ODOM: begin
                    r_a    <= OP_W'(i_in_data.pos_x) - OP_W'(r_corr_x);
                    r_b    <= OP_W'(i_in_data.pos_y) - OP_W'(r_corr_y);
                    r_offx <= '0;
                    r_offy <= '0;
                end
                ACT_SET: begin
                    r_a    <= OP_W'(i_in_data.pos_x);
                    r_b    <= OP_W'(i_in_data.pos_y);
                    r_offx <= '0;
                    r_offy <= '0;
                end
                ACT_COMPOSE: begin
                    r_a    <= OP_W'(r_corr_x);
                    r_b    <= OP_W'(r_corr_y);
                    r_offx <= i_in_data.pos_x;
                    r_offy <= i_in_data.pos_y;
                end
                default: ;
            endcase
        end
    end

    // one cordic micro-rotation per cycle
    logic signed [CORDIC_W-1:0] sh_x, sh_y;
    logic signed [Z_W-1:0]      atan_z;
    always_comb begin
        sh_x   = r_cx >>> i_cmd.step_idx;
        sh_y   = r_cy >>> i_cmd.step_idx;
        atan_z = Z_W'(atan_lut(i_cmd.step_idx));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= CORDIC_START;
            r_cy <= '0;
            r_z  <= Z_W'($signed({ang_fold, 16'h0000}));
        end else if (i_cmd.cordic_step) begin
            if (!r_z[Z_W-1]) begin
                r_cx <= r_cx - sh_y;
                r_cy <= r_cy + sh_x;
                r_z  <= r_z - atan_z;
            end else begin
                r_cx <= r_cx + sh_y;
                r_cy <= r_cy - sh_x;
                r_z  <= r_z + atan_z;
            end
        end
    end

    // shared multiplier, product registered before accumulation
    logic signed [CORDIC_W-1:0] cos_v, sin_v, trig_op;
    logic signed [OP_W-1:0]     pos_op;
    always_comb begin
        cos_v   = r_flip ? -r_cx : r_cx;
        sin_v   = r_flip ? -r_cy : r_cy;
        pos_op  = ((i_cmd.mul_sel == MS_AC) || (i_cmd.mul_sel == MS_AS)) ? r_a : r_b;
        trig_op = ((i_cmd.mul_sel == MS_AC) || (i_cmd.mul_sel == MS_BC)) ? cos_v : sin_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(pos_op * trig_op);
        end
    end

    // signed accumulation of the partial products
    logic signed [ACC_W-1:0] prod_ext;
    logic                    sub_s;
    assign prod_ext = ACC_W'(r_prod);
    assign sub_s    = (r_act == ACT_TO_ODOM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_accx <= '0;
            r_accy <= '0;
        end else if (i_cmd.acc_en) begin
            unique case (i_cmd.acc_sel)
                MS_AC:   r_accx <= r_accx + prod_ext;
                MS_BS:   r_accx <= sub_s ? (r_accx - prod_ext) : (r_accx + prod_ext);
                MS_BC:   r_accy <= r_accy + prod_ext;
                MS_AS:   r_accy <= sub_s ? (r_accy + prod_ext) : (r_accy - prod_ext);
                default: ;
            endcase
        end
    end

    // round half up, add offset, clamp
    logic signed [ACC_W-1:0] rnd_x, rnd_y;
    logic signed [RES_W-1:0] res_x, res_y;
    logic signed [15:0]      clp_x, clp_y;
    logic                    sat_x, sat_y;
    always_comb begin
        rnd_x = r_accx + RND_HALF;
        rnd_y = r_accy + RND_HALF;
        res_x = RES_W'($signed(rnd_x[ACC_W-1:30])) + RES_W'(r_offx);
        res_y = RES_W'($signed(rnd_y[ACC_W-1:30])) + RES_W'(r_offy);
        sat_x = (res_x > POS_MAX) || (res_x < POS_MIN);
        sat_y = (res_y > POS_MAX) || (res_y < POS_MIN);
        clp_x = (res_x > POS_MAX) ? 16'sh7FFF : (res_x < POS_MIN) ? -16'sh8000 : res_x[15:0];
        clp_y = (res_y > POS_MAX) ? 16'sh7FFF : (res_y < POS_MIN) ? -16'sh8000 : res_y[15:0];
    end

    // result selection and correction update
    t_out_item res;
    always_comb begin
        res.out_x     = clp_x;
        res.out_y     = clp_y;
        res.saturated = sat_x || sat_y;
        res.out_angle = r_pa + r_corr_a;
        unique case (r_act)
            ACT_TO_TABLE: res.out_angle = r_pa - r_corr_a;
            ACT_TO_ODOM:  res.out_angle = r_pa + r_corr_a;
            ACT_SET: begin
                res.out_x     = r_a[15:0];
                res.out_y     = r_b[15:0];
                res.out_angle = r_pa;
                res.saturated = 1'b0;
            end
            ACT_COMPOSE:  res.out_angle = r_corr_a + r_pa;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_x <= '0;
            r_corr_y <= '0;
            r_corr_a <= '0;
        end else if (i_cmd.finish && ((r_act == ACT_SET) || (r_act == ACT_COMPOSE))) begin
            r_corr_x <= res.out_x;
            r_corr_y <= res.out_y;
            r_corr_a <= res.out_angle;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= res;
        end
    end

    assign o_out_data = r_out;

endmodule

### tb/sv/pose_frame_correction_test.sv
// self-checking testbench for the pose frame correction block
module pose_frame_correction_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam int ROT_STEPS    = (CORDIC_STEPS < 1) ? 1 : (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int SETTLE       = ROT_STEPS + 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;

    // block interface
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;

    // traffic shaping
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    // run bookkeeping
    int     cycle_count    = 0;
    int     sent_count     = 0;
    int     checked_count  = 0;
    int     mismatch_count = 0;
    int     action_seen [4] = '{0, 0, 0, 0};
    int     sat_seen       = 0;

    // predicted pose corrections and expected transactions
    logic signed [15:0] offset_x  = '0;
    logic signed [15:0] offset_y  = '0;
    logic        [15:0] heading_q = '0;
    t_out_item          pending_poses [$];

    // arctangent of 2^-k, 2^32 per turn
    longint arctan_step [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    pose_frame_correction u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transactions still pending",
                     cycle_count, pending_poses.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sine and cosine in q30 from a rotation-mode cordic, with quadrant fold
    function automatic void rotation_sincos(input logic [15:0] heading,
                                            output longint cos_q30, output longint sin_q30);
        logic [15:0] folded;
        bit          flip;
        longint      vx, vy, vz, nx;
        folded = heading;
        flip   = 1'b0;
        if (folded >= 16'h4000 && folded < 16'hC000) begin
            folded = folded ^ 16'h8000;
            flip   = 1'b1;
        end
        vx = 64'h26DD3B6A;
        vy = 0;
        vz = longint'($signed(folded)) * 65536;
        for (int k = 0; k < ROT_STEPS; k++) begin
            if (vz >= 0) begin
                nx = vx - (vy >>> k);
                vy = vy + (vx >>> k);
                vz = vz - arctan_step[k];
            end else begin
                nx = vx + (vy >>> k);
                vy = vy - (vx >>> k);
                vz = vz + arctan_step[k];
            end
            vx = nx;
        end
        cos_q30 = flip ? -vx : vx;
        sin_q30 = flip ? -vy : vy;
    endfunction

    // round a q30 sum half up to millimetres
    function automatic longint round_q30(input longint acc);
        return (acc + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic logic [15:0] clamp_coord(input longint v, inout bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'h7FFF;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // expected result of one input transaction, updates the predicted correction
    function automatic t_out_item frame_transform(input t_in_item item);
        t_out_item res;
        longint    c, s, px, py, dx, dy, cx, cy;
        bit        sat;
        sat = 1'b0;
        px  = longint'($signed(item.pos_x));
        py  = longint'($signed(item.pos_y));
        res = '0;
        case (item.action)
            ACT_TO_TABLE: begin
                rotation_sincos(heading_q, c, s);
                res.out_x     = clamp_coord(round_q30(px * c + py * s) + offset_x, sat);
                res.out_y     = clamp_coord(round_q30(-px * s + py * c) + offset_y, sat);
                res.out_angle = item.pos_angle - heading_q;
            end
            ACT_TO_ODOM: begin
                dx = px - longint'(offset_x);
                dy = py - longint'(offset_y);
                rotation_sincos(heading_q, c, s);
                res.out_x     = clamp_coord(round_q30(dx * c - dy * s), sat);
                res.out_y     = clamp_coord(round_q30(dx * s + dy * c), sat);
                res.out_angle = item.pos_angle + heading_q;
            end
            ACT_SET: begin
                offset_x  = item.pos_x;
                offset_y  = item.pos_y;
                heading_q = item.pos_angle;
                res.out_x     = offset_x;
                res.out_y     = offset_y;
                res.out_angle = heading_q;
            end
            default: begin
                // compose uses the old offset in both lines
                cx = longint'(offset_x);
                cy = longint'(offset_y);
                rotation_sincos(item.pos_angle, c, s);
                offset_x  = clamp_coord(round_q30(cx * c + cy * s) + px, sat);
                offset_y  = clamp_coord(round_q30(-cx * s + cy * c) + py, sat);
                heading_q = heading_q + item.pos_angle;
                res.out_x     = offset_x;
                res.out_y     = offset_y;
                res.out_angle = heading_q;
            end
        endcase
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        mismatch_count++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // predict on each accepted input, check each accepted result
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                pending_poses.push_back(frame_transform(in_data));
                action_seen[in_data.action]++;
            end
            if (out_valid && !out_stall) begin
                if (pending_poses.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result with nothing pending, x %0d y %0d angle %0d",
                             $time, out_data.out_x, out_data.out_y, out_data.out_angle);
                end else begin
                    want = pending_poses.pop_front();
                    checked_count++;
                    if (want.saturated)
                        sat_seen++;
                    if (out_data.out_x !== want.out_x)
                        report_field("out_x", int'(want.out_x), int'(out_data.out_x));
                    if (out_data.out_y !== want.out_y)
                        report_field("out_y", int'(want.out_y), int'(out_data.out_y));
                    if (out_data.out_angle !== want.out_angle)
                        report_field("out_angle", int'(want.out_angle),
                                     int'(out_data.out_angle));
                    if (out_data.saturated !== want.saturated)
                        report_field("saturated", int'(want.saturated),
                                     int'(out_data.saturated));
                end
            end
        end
    end

    // result side stall, with an occasional long hold-off
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // offer one transaction after a random gap and wait for it to be taken
    task automatic send_pose(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // every sent transaction has had its result checked
    task automatic wait_for_results();
        while (checked_count < sent_count)
            @(posedge clk);
    endtask

    function automatic t_in_item pose(input t_action act, input logic [15:0] x,
                                      input logic [15:0] y, input logic [15:0] a);
        t_in_item item;
        item.action    = act;
        item.pos_x     = x;
        item.pos_y     = y;
        item.pos_angle = a;
        return item;
    endfunction

    // coordinates biased towards the extremes and towards moderate values
    function automatic logic [15:0] random_coord();
        case ($urandom_range(15))
            0:             return 16'h7FFF;
            1:             return 16'h8000;
            2:             return 16'h0000;
            3:             return 16'hFFFF;
            4, 5, 6, 7, 8: return 16'(int'($urandom_range(4000)) - 2000);
            default:       return 16'($urandom);
        endcase
    endfunction

    // headings biased towards quadrant boundaries and wrap points
    function automatic logic [15:0] random_heading();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'h4000;
            2:       return 16'h8000;
            3:       return 16'hC000;
            4:       return 16'h3FFF;
            5:       return 16'hBFFF;
            6:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_pose();
        int       pick;
        t_action  act;
        pick = $urandom_range(99);
        if (pick < 35)
            act = ACT_TO_TABLE;
        else if (pick < 70)
            act = ACT_TO_ODOM;
        else if (pick < 82)
            act = ACT_SET;
        else
            act = ACT_COMPOSE;
        // compose deltas stay small most of the time so the correction keeps meaning
        if (act == ACT_COMPOSE && $urandom_range(3) != 0)
            return pose(act, 16'(int'($urandom_range(200)) - 100),
                        16'(int'($urandom_range(200)) - 100), 16'($urandom_range(2047)));
        return pose(act, random_coord(), random_coord(), random_heading());
    endfunction

    // extremes, every action, quadrant folds, wrap and saturation
    task automatic test_directed();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_pose(pose(ACT_TO_TABLE, 16'h0000, 16'h0000, 16'h0000));
        send_pose(pose(ACT_TO_TABLE, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_pose(pose(ACT_TO_ODOM,  16'h8000, 16'h7FFF, 16'h0001));
        send_pose(pose(ACT_SET,      16'd1000, -16'sd2000, 16'h4000));
        send_pose(pose(ACT_TO_TABLE, 16'h7FFF, 16'h7FFF, 16'h0000));
        send_pose(pose(ACT_TO_ODOM,  16'h8000, 16'h8000, 16'hC000));
        send_pose(pose(ACT_SET,      16'h7FFF, 16'h8000, 16'h8000));
        send_pose(pose(ACT_TO_TABLE, 16'h8000, 16'h7FFF, 16'h1234));
        send_pose(pose(ACT_TO_ODOM,  16'h7FFF, 16'h8000, 16'h8000));
        send_pose(pose(ACT_TO_ODOM,  16'h8000, 16'h7FFF, 16'h7FFF));
        send_pose(pose(ACT_SET,      16'h0000, 16'h0000, 16'h3FFF));
        send_pose(pose(ACT_TO_TABLE, 16'd300, 16'd400, 16'h0000));
        send_pose(pose(ACT_SET,      16'h0000, 16'h0000, 16'hC000));
        send_pose(pose(ACT_TO_TABLE, 16'd100, 16'd200, 16'h0000));
        send_pose(pose(ACT_SET,      16'd50, -16'sd60, 16'hBFFF));
        send_pose(pose(ACT_TO_ODOM,  16'd100, 16'd200, 16'hFFFF));
        send_pose(pose(ACT_SET,      16'd30000, 16'd30000, 16'h0000));
        send_pose(pose(ACT_COMPOSE,  16'd5, -16'sd7, 16'h2000));
        send_pose(pose(ACT_COMPOSE,  16'h7FFF, 16'h7FFF, 16'hFFFF));
        send_pose(pose(ACT_COMPOSE,  16'h8000, 16'h8000, 16'h8000));
        send_pose(pose(ACT_COMPOSE,  16'd0, 16'd0, 16'h4000));
        send_pose(pose(ACT_SET,      16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pose(pose(ACT_TO_ODOM,  16'h0000, 16'h0000, 16'h0001));
        send_pose(pose(ACT_SET,      16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (count)
            send_pose(random_pose());
    endtask

    // hold the result side off so the block fills and stalls its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left <= HOLD_CYCLES;
        repeat (12)
            send_pose(random_pose());
    endtask

    // sender pauses until every pending transaction has come back
    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        repeat (6)
            send_pose(random_pose());
        in_valid <= 1'b0;
        wait_for_results();
        repeat (6)
            send_pose(random_pose());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(170, 38, 70);
        test_backpressure();
        test_random_traffic(170, 70, 38);
        test_drain_pause();
        test_random_traffic(160, 0, 0);
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d transactions: %0d to table, %0d to odometry, %0d set, %0d compose",
                 sent_count, action_seen[ACT_TO_TABLE], action_seen[ACT_TO_ODOM],
                 action_seen[ACT_SET], action_seen[ACT_COMPOSE]);
        $display("checked %0d results (%0d clamped), %0d field errors, %0d cycles",
                 checked_count, sat_seen, mismatch_count, cycle_count);
        if (mismatch_count == 0 && pending_poses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
